// ===== hw/rtl/acm_pkg.sv =====
`timescale 1ns / 1ps
package acm_pkg;

   localparam int MAX_NODES       = 1024;
   localparam int MAX_PATTERNS    = 1024;
   localparam int MAX_PATTERN_LEN = 1024;
   localparam int ALPHABET        = 256;
   localparam int MAX_HITS        = 64;
   localparam int POS_BITS        = 20;

   localparam int CMD_W   = 2;
   localparam int SYM_W   = 8;
   localparam int ID_W    = 10;
   localparam int START_W = 20;

   localparam int NODE_BITS  = $clog2(MAX_NODES);
   localparam int CNT_BITS   = NODE_BITS + 1;
   localparam int PAT_BITS   = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
   localparam int PCNT_BITS  = $clog2(MAX_PATTERNS + 1);
   localparam int DEPTH_BITS = $clog2(MAX_PATTERN_LEN + 1);
   localparam int SYM_BITS   = $clog2(ALPHABET);
   localparam int GOTO_BITS  = NODE_BITS + SYM_BITS;
   localparam int GOTO_DEPTH = MAX_NODES * ALPHABET;
   localparam int HIT_BITS   = $clog2(MAX_HITS + 1);

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BUILD  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SCAN   = 2'd2;
   // unused code, ignored by the block
   localparam logic [CMD_W-1:0] CMD_RSVD   = 2'd3;

   localparam logic KIND_MATCH = 1'b0;
   localparam logic KIND_BUILD = 1'b1;

   typedef struct packed {
      logic                 valid;
      logic [NODE_BITS-1:0] idx;
   } node_ref_type;

   typedef struct packed {
      logic [NODE_BITS-1:0] fail;
      logic                 dict_v;
      logic [NODE_BITS-1:0] dict;
   } link_type;

   typedef struct packed {
      logic                  fp_v;
      logic [PAT_BITS-1:0]   fp;
      logic [DEPTH_BITS-1:0] depth;
   } info_type;

   typedef struct packed {
      logic                valid;
      logic [PAT_BITS-1:0] idx;
   } chain_type;

   typedef struct packed {
      logic               kind;
      logic [ID_W-1:0]    pattern_id;
      logic [START_W-1:0] start_pos;
      logic               overflow;
      logic               last;
   } result_type;

endpackage

// ===== hw/rtl/acm_ram.sv =====
`timescale 1ns / 1ps
module acm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/acm_core.sv =====
`timescale 1ns / 1ps
module acm_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [acm_pkg::CMD_W-1:0]   req_cmd,
   input  logic [acm_pkg::SYM_W-1:0]   req_symbol,
   input  logic                        req_pattern_end,
   output logic                        emit_valid,
   output acm_pkg::result_type         emit,
   input  logic                        slot_free
);
   import acm_pkg::*;

   localparam logic [4:0] S_CLR     = 5'd0;
   localparam logic [4:0] S_IDLE    = 5'd1;
   localparam logic [4:0] S_INS_RD  = 5'd2;
   localparam logic [4:0] S_INS_CHK = 5'd3;
   localparam logic [4:0] S_FIN     = 5'd4;
   localparam logic [4:0] S_FIN_CHK = 5'd5;
   localparam logic [4:0] S_CH_CHK  = 5'd6;
   localparam logic [4:0] S_BR_RD   = 5'd7;
   localparam logic [4:0] S_BR_CHK  = 5'd8;
   localparam logic [4:0] S_BQ_RD   = 5'd9;
   localparam logic [4:0] S_BQ_U    = 5'd10;
   localparam logic [4:0] S_BQ_F    = 5'd11;
   localparam logic [4:0] S_BC_RD   = 5'd12;
   localparam logic [4:0] S_BC_CHK  = 5'd13;
   localparam logic [4:0] S_BF_TEST = 5'd14;
   localparam logic [4:0] S_BF_CHK  = 5'd15;
   localparam logic [4:0] S_BF_LNK  = 5'd16;
   localparam logic [4:0] S_BW      = 5'd17;
   localparam logic [4:0] S_BW_CHK  = 5'd18;
   localparam logic [4:0] S_BDONE   = 5'd19;
   localparam logic [4:0] S_SC_RD   = 5'd20;
   localparam logic [4:0] S_SC_CHK  = 5'd21;
   localparam logic [4:0] S_SC_LNK  = 5'd22;
   localparam logic [4:0] S_SC_V    = 5'd23;
   localparam logic [4:0] S_SC_VCHK = 5'd24;
   localparam logic [4:0] S_SC_NODE = 5'd25;
   localparam logic [4:0] S_SC_NCHK = 5'd26;
   localparam logic [4:0] S_SC_P    = 5'd27;
   localparam logic [4:0] S_SC_PCHK = 5'd28;
   localparam logic [4:0] S_SC_END  = 5'd29;

   localparam logic [NODE_BITS-1:0] ROOT    = '0;
   localparam logic [SYM_BITS-1:0]  SYM_TOP = SYM_BITS'(ALPHABET - 1);

   // control registers
   logic [4:0]            state_ff, state_in;
   logic [GOTO_BITS-1:0]  clr_ff, clr_in;
   logic [CNT_BITS-1:0]   node_count_ff, node_count_in;
   logic [PCNT_BITS-1:0]  pat_count_ff, pat_count_in;
   logic [NODE_BITS-1:0]  ins_node_ff, ins_node_in;
   logic                  drop_ff, drop_in;
   logic                  store_full_ff, store_full_in;
   logic [NODE_BITS-1:0]  scan_node_ff, scan_node_in;
   logic [POS_BITS-1:0]   text_pos_ff, text_pos_in;
   logic [CNT_BITS-1:0]   head_ff, head_in;
   logic [CNT_BITS-1:0]   tail_ff, tail_in;
   logic [HIT_BITS-1:0]   hits_ff, hits_in;
   logic                  dropped_ff, dropped_in;
   logic                  pend_v_ff, pend_v_in;

   // payload registers
   logic [SYM_BITS-1:0]   sym_ff, sym_in;
   logic                  end_ff, end_in;
   logic [PAT_BITS-1:0]   pat_id_ff, pat_id_in;
   logic [PAT_BITS-1:0]   walk_ff, walk_in;
   logic [SYM_BITS-1:0]   c_ff, c_in;
   logic [NODE_BITS-1:0]  u_ff, u_in;
   logic [NODE_BITS-1:0]  fu_ff, fu_in;
   logic [NODE_BITS-1:0]  v_ff, v_in;
   logic [NODE_BITS-1:0]  f_ff, f_in;
   logic [NODE_BITS-1:0]  w_ff, w_in;
   node_ref_type          cur_ref_ff, cur_ref_in;
   node_ref_type          next_ref_ff, next_ref_in;
   chain_type             pat_ref_ff, pat_ref_in;
   logic [DEPTH_BITS-1:0] depth_ff, depth_in;
   logic [PAT_BITS-1:0]   pend_id_ff, pend_id_in;
   logic [POS_BITS-1:0]   pend_pos_ff, pend_pos_in;

   // memory ports
   logic                  g_we;
   logic [GOTO_BITS-1:0]  g_waddr, g_raddr;
   node_ref_type          g_wdata, g_rdata;
   logic                  l_we;
   logic [NODE_BITS-1:0]  l_waddr, l_raddr;
   link_type              l_wdata, l_rdata;
   logic                  i_we;
   logic [NODE_BITS-1:0]  i_waddr, i_raddr;
   info_type              i_wdata, i_rdata;
   logic                  c_we;
   logic [PAT_BITS-1:0]   c_waddr, c_raddr;
   chain_type             c_wdata, c_rdata;
   logic                  q_we;
   logic [NODE_BITS-1:0]  q_waddr, q_raddr;
   logic [NODE_BITS-1:0]  q_wdata, q_rdata;

   logic [DEPTH_BITS-1:0] ins_depth;
   logic [DEPTH_BITS:0]   ins_depth_next;
   logic [POS_BITS-1:0]   hit_pos;
   logic                  sym_ok;

   acm_ram #(.WIDTH($bits(node_ref_type)), .DEPTH(GOTO_DEPTH)) u_goto (
      .clock(clock), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
      .raddr(g_raddr), .rdata(g_rdata)
   );
   acm_ram #(.WIDTH($bits(link_type)), .DEPTH(MAX_NODES)) u_link (
      .clock(clock), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
      .raddr(l_raddr), .rdata(l_rdata)
   );
   acm_ram #(.WIDTH($bits(info_type)), .DEPTH(MAX_NODES)) u_info (
      .clock(clock), .we(i_we), .waddr(i_waddr), .wdata(i_wdata),
      .raddr(i_raddr), .rdata(i_rdata)
   );
   acm_ram #(.WIDTH($bits(chain_type)), .DEPTH(1 << PAT_BITS)) u_chain (
      .clock(clock), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
      .raddr(c_raddr), .rdata(c_rdata)
   );
   acm_ram #(.WIDTH(NODE_BITS), .DEPTH(MAX_NODES)) u_queue (
      .clock(clock), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
      .raddr(q_raddr), .rdata(q_rdata)
   );

   assign req_ready      = (state_ff == S_IDLE);
   assign sym_ok         = ({1'b0, req_symbol} < (SYM_W + 1)'(ALPHABET));
   // root has depth zero and its info entry is never written
   assign ins_depth      = (ins_node_ff == ROOT) ? '0 : i_rdata.depth;
   assign ins_depth_next = {1'b0, ins_depth} + (DEPTH_BITS + 1)'(1);
   assign hit_pos        = text_pos_ff - POS_BITS'(depth_ff) + POS_BITS'(1);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      node_count_in = node_count_ff;
      pat_count_in  = pat_count_ff;
      ins_node_in   = ins_node_ff;
      drop_in       = drop_ff;
      store_full_in = store_full_ff;
      scan_node_in  = scan_node_ff;
      text_pos_in   = text_pos_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      hits_in       = hits_ff;
      dropped_in    = dropped_ff;
      pend_v_in     = pend_v_ff;
      sym_in        = sym_ff;
      end_in        = end_ff;
      pat_id_in     = pat_id_ff;
      walk_in       = walk_ff;
      c_in          = c_ff;
      u_in          = u_ff;
      fu_in         = fu_ff;
      v_in          = v_ff;
      f_in          = f_ff;
      w_in          = w_ff;
      cur_ref_in    = cur_ref_ff;
      next_ref_in   = next_ref_ff;
      pat_ref_in    = pat_ref_ff;
      depth_in      = depth_ff;
      pend_id_in    = pend_id_ff;
      pend_pos_in   = pend_pos_ff;

      g_we = 1'b0; g_waddr = '0; g_wdata = '0; g_raddr = '0;
      l_we = 1'b0; l_waddr = '0; l_wdata = '0; l_raddr = '0;
      i_we = 1'b0; i_waddr = '0; i_wdata = '0; i_raddr = '0;
      c_we = 1'b0; c_waddr = '0; c_wdata = '0; c_raddr = '0;
      q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;

      emit_valid = 1'b0;
      emit       = '0;

      case (state_ff)
         S_CLR: begin
            g_we    = 1'b1;
            g_waddr = clr_ff;
            clr_in  = clr_ff + GOTO_BITS'(1);
            if (clr_ff == GOTO_BITS'(GOTO_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               sym_in = req_symbol[SYM_BITS-1:0];
               end_in = req_pattern_end;
               case (req_cmd)
                  CMD_INSERT: begin
                     if (!sym_ok) begin
                        state_in = S_IDLE;
                     end else if (drop_ff) begin
                        state_in = req_pattern_end ? S_FIN : S_IDLE;
                     end else begin
                        state_in = S_INS_RD;
                     end
                  end
                  CMD_BUILD: begin
                     c_in     = '0;
                     head_in  = '0;
                     tail_in  = '0;
                     state_in = S_BR_RD;
                  end
                  CMD_SCAN: begin
                     if (!sym_ok) begin
                        scan_node_in = ROOT;
                        text_pos_in  = text_pos_ff + POS_BITS'(1);
                     end else begin
                        hits_in    = '0;
                        dropped_in = 1'b0;
                        state_in   = S_SC_RD;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_INS_RD: begin
            g_raddr  = {ins_node_ff, sym_ff};
            i_raddr  = ins_node_ff;
            state_in = S_INS_CHK;
         end
         S_INS_CHK: begin
            if (g_rdata.valid) begin
               ins_node_in = g_rdata.idx;
            end else if (node_count_ff >= CNT_BITS'(MAX_NODES) ||
                         ins_depth_next > (DEPTH_BITS + 1)'(MAX_PATTERN_LEN)) begin
               store_full_in = 1'b1;
               drop_in       = 1'b1;
            end else begin
               g_we          = 1'b1;
               g_waddr       = {ins_node_ff, sym_ff};
               g_wdata       = '{valid: 1'b1, idx: node_count_ff[NODE_BITS-1:0]};
               l_we          = 1'b1;
               l_waddr       = node_count_ff[NODE_BITS-1:0];
               i_we          = 1'b1;
               i_waddr       = node_count_ff[NODE_BITS-1:0];
               i_wdata.depth = ins_depth_next[DEPTH_BITS-1:0];
               node_count_in = node_count_ff + CNT_BITS'(1);
               ins_node_in   = node_count_ff[NODE_BITS-1:0];
            end
            state_in = end_ff ? S_FIN : S_IDLE;
         end
         S_FIN: begin
            if (pat_count_ff >= PCNT_BITS'(MAX_PATTERNS)) begin
               store_full_in = 1'b1;
               ins_node_in   = ROOT;
               drop_in       = 1'b0;
               state_in      = S_IDLE;
            end else begin
               pat_id_in    = pat_count_ff[PAT_BITS-1:0];
               pat_count_in = pat_count_ff + PCNT_BITS'(1);
               if (!drop_ff && ins_node_ff != ROOT) begin
                  c_we     = 1'b1;
                  c_waddr  = pat_count_ff[PAT_BITS-1:0];
                  i_raddr  = ins_node_ff;
                  state_in = S_FIN_CHK;
               end else begin
                  ins_node_in = ROOT;
                  drop_in     = 1'b0;
                  state_in    = S_IDLE;
               end
            end
         end
         S_FIN_CHK: begin
            if (!i_rdata.fp_v) begin
               i_we          = 1'b1;
               i_waddr       = ins_node_ff;
               i_wdata.fp_v  = 1'b1;
               i_wdata.fp    = pat_id_ff;
               i_wdata.depth = i_rdata.depth;
               ins_node_in   = ROOT;
               drop_in       = 1'b0;
               state_in      = S_IDLE;
            end else begin
               walk_in  = i_rdata.fp;
               c_raddr  = i_rdata.fp;
               state_in = S_CH_CHK;
            end
         end
         S_CH_CHK: begin
            // walk to the tail of this node's id chain
            if (c_rdata.valid) begin
               walk_in = c_rdata.idx;
               c_raddr = c_rdata.idx;
            end else begin
               c_we        = 1'b1;
               c_waddr     = walk_ff;
               c_wdata     = '{valid: 1'b1, idx: pat_id_ff};
               ins_node_in = ROOT;
               drop_in     = 1'b0;
               state_in    = S_IDLE;
            end
         end
         S_BR_RD: begin
            g_raddr  = {ROOT, c_ff};
            state_in = S_BR_CHK;
         end
         S_BR_CHK: begin
            if (g_rdata.valid) begin
               l_we    = 1'b1;
               l_waddr = g_rdata.idx;
               if (tail_ff < CNT_BITS'(MAX_NODES)) begin
                  q_we    = 1'b1;
                  q_waddr = tail_ff[NODE_BITS-1:0];
                  q_wdata = g_rdata.idx;
                  tail_in = tail_ff + CNT_BITS'(1);
               end
            end
            if (c_ff == SYM_TOP) begin
               state_in = S_BQ_RD;
            end else begin
               c_in     = c_ff + SYM_BITS'(1);
               state_in = S_BR_RD;
            end
         end
         S_BQ_RD: begin
            if (head_ff < tail_ff) begin
               q_raddr  = head_ff[NODE_BITS-1:0];
               head_in  = head_ff + CNT_BITS'(1);
               state_in = S_BQ_U;
            end else begin
               state_in = S_BDONE;
            end
         end
         S_BQ_U: begin
            u_in     = q_rdata;
            l_raddr  = q_rdata;
            c_in     = '0;
            state_in = S_BQ_F;
         end
         S_BQ_F: begin
            fu_in    = l_rdata.fail;
            state_in = S_BC_RD;
         end
         S_BC_RD: begin
            g_raddr  = {u_ff, c_ff};
            state_in = S_BC_CHK;
         end
         S_BC_CHK: begin
            if (g_rdata.valid) begin
               v_in = g_rdata.idx;
               if (tail_ff < CNT_BITS'(MAX_NODES)) begin
                  q_we    = 1'b1;
                  q_waddr = tail_ff[NODE_BITS-1:0];
                  q_wdata = g_rdata.idx;
                  tail_in = tail_ff + CNT_BITS'(1);
               end
               f_in     = fu_ff;
               state_in = S_BF_TEST;
            end else if (c_ff == SYM_TOP) begin
               state_in = S_BQ_RD;
            end else begin
               c_in     = c_ff + SYM_BITS'(1);
               state_in = S_BC_RD;
            end
         end
         S_BF_TEST: begin
            g_raddr  = {f_ff, c_ff};
            state_in = S_BF_CHK;
         end
         S_BF_CHK: begin
            if (g_rdata.valid) begin
               w_in     = g_rdata.idx;
               state_in = S_BW;
            end else if (f_ff == ROOT) begin
               w_in     = ROOT;
               state_in = S_BW;
            end else begin
               l_raddr  = f_ff;
               state_in = S_BF_LNK;
            end
         end
         S_BF_LNK: begin
            f_in     = l_rdata.fail;
            state_in = S_BF_TEST;
         end
         S_BW: begin
            if (w_ff == ROOT) begin
               // fail to root: no dictionary suffix
               l_we    = 1'b1;
               l_waddr = v_ff;
               if (c_ff == SYM_TOP) begin
                  state_in = S_BQ_RD;
               end else begin
                  c_in     = c_ff + SYM_BITS'(1);
                  state_in = S_BC_RD;
               end
            end else begin
               i_raddr  = w_ff;
               l_raddr  = w_ff;
               state_in = S_BW_CHK;
            end
         end
         S_BW_CHK: begin
            l_we         = 1'b1;
            l_waddr      = v_ff;
            l_wdata.fail = w_ff;
            if (i_rdata.fp_v) begin
               l_wdata.dict_v = 1'b1;
               l_wdata.dict   = w_ff;
            end else begin
               l_wdata.dict_v = l_rdata.dict_v;
               l_wdata.dict   = l_rdata.dict;
            end
            if (c_ff == SYM_TOP) begin
               state_in = S_BQ_RD;
            end else begin
               c_in     = c_ff + SYM_BITS'(1);
               state_in = S_BC_RD;
            end
         end
         S_BDONE: begin
            if (slot_free) begin
               emit_valid     = 1'b1;
               emit.kind      = KIND_BUILD;
               emit.overflow  = store_full_ff;
               emit.last      = 1'b1;
               scan_node_in   = ROOT;
               text_pos_in    = '0;
               state_in       = S_IDLE;
            end
         end
         S_SC_RD: begin
            g_raddr  = {scan_node_ff, sym_ff};
            state_in = S_SC_CHK;
         end
         S_SC_CHK: begin
            if (g_rdata.valid) begin
               scan_node_in = g_rdata.idx;
               state_in     = S_SC_V;
            end else if (scan_node_ff == ROOT) begin
               state_in = S_SC_V;
            end else begin
               l_raddr  = scan_node_ff;
               state_in = S_SC_LNK;
            end
         end
         S_SC_LNK: begin
            scan_node_in = l_rdata.fail;
            state_in     = S_SC_RD;
         end
         S_SC_V: begin
            if (scan_node_ff == ROOT) begin
               state_in = S_SC_END;
            end else begin
               i_raddr  = scan_node_ff;
               l_raddr  = scan_node_ff;
               state_in = S_SC_VCHK;
            end
         end
         S_SC_VCHK: begin
            if (i_rdata.fp_v) begin
               cur_ref_in = '{valid: 1'b1, idx: scan_node_ff};
            end else begin
               cur_ref_in = '{valid: l_rdata.dict_v, idx: l_rdata.dict};
            end
            state_in = S_SC_NODE;
         end
         S_SC_NODE: begin
            if (!cur_ref_ff.valid) begin
               state_in = S_SC_END;
            end else begin
               i_raddr  = cur_ref_ff.idx;
               l_raddr  = cur_ref_ff.idx;
               state_in = S_SC_NCHK;
            end
         end
         S_SC_NCHK: begin
            depth_in    = i_rdata.depth;
            next_ref_in = '{valid: l_rdata.dict_v, idx: l_rdata.dict};
            pat_ref_in  = '{valid: i_rdata.fp_v, idx: i_rdata.fp};
            state_in    = S_SC_P;
         end
         S_SC_P: begin
            if (!pat_ref_ff.valid) begin
               cur_ref_in = next_ref_ff;
               state_in   = S_SC_NODE;
            end else if (hits_ff >= HIT_BITS'(MAX_HITS)) begin
               dropped_in = 1'b1;
               state_in   = S_SC_END;
            end else if (!pend_v_ff || slot_free) begin
               // the held hit goes out once we know it is not the last
               if (pend_v_ff) begin
                  emit_valid      = 1'b1;
                  emit.kind       = KIND_MATCH;
                  emit.pattern_id = ID_W'(pend_id_ff);
                  emit.start_pos  = START_W'(pend_pos_ff);
               end
               pend_v_in   = 1'b1;
               pend_id_in  = pat_ref_ff.idx;
               pend_pos_in = hit_pos;
               hits_in     = hits_ff + HIT_BITS'(1);
               c_raddr     = pat_ref_ff.idx;
               state_in    = S_SC_PCHK;
            end
         end
         S_SC_PCHK: begin
            pat_ref_in = c_rdata;
            state_in   = S_SC_P;
         end
         S_SC_END: begin
            if (!pend_v_ff) begin
               text_pos_in = text_pos_ff + POS_BITS'(1);
               state_in    = S_IDLE;
            end else if (slot_free) begin
               emit_valid      = 1'b1;
               emit.kind       = KIND_MATCH;
               emit.pattern_id = ID_W'(pend_id_ff);
               emit.start_pos  = START_W'(pend_pos_ff);
               emit.overflow   = dropped_ff;
               emit.last       = 1'b1;
               pend_v_in       = 1'b0;
               text_pos_in     = text_pos_ff + POS_BITS'(1);
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLR;
         clr_ff        <= '0;
         node_count_ff <= CNT_BITS'(1);
         pat_count_ff  <= '0;
         ins_node_ff   <= ROOT;
         drop_ff       <= 1'b0;
         store_full_ff <= 1'b0;
         scan_node_ff  <= ROOT;
         text_pos_ff   <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         hits_ff       <= '0;
         dropped_ff    <= 1'b0;
         pend_v_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         node_count_ff <= node_count_in;
         pat_count_ff  <= pat_count_in;
         ins_node_ff   <= ins_node_in;
         drop_ff       <= drop_in;
         store_full_ff <= store_full_in;
         scan_node_ff  <= scan_node_in;
         text_pos_ff   <= text_pos_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         hits_ff       <= hits_in;
         dropped_ff    <= dropped_in;
         pend_v_ff     <= pend_v_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff      <= sym_in;
      end_ff      <= end_in;
      pat_id_ff   <= pat_id_in;
      walk_ff     <= walk_in;
      c_ff        <= c_in;
      u_ff        <= u_in;
      fu_ff       <= fu_in;
      v_ff        <= v_in;
      f_ff        <= f_in;
      w_ff        <= w_in;
      cur_ref_ff  <= cur_ref_in;
      next_ref_ff <= next_ref_in;
      pat_ref_ff  <= pat_ref_in;
      depth_ff    <= depth_in;
      pend_id_ff  <= pend_id_in;
      pend_pos_ff <= pend_pos_in;
   end

`ifndef NO_ASSERTIONS
   a_node_bound: assert property (@(posedge clock) disable iff (reset)
      node_count_ff <= CNT_BITS'(MAX_NODES))
      else $error("node count beyond store");
   a_hit_bound: assert property (@(posedge clock) disable iff (reset)
      hits_ff <= HIT_BITS'(MAX_HITS))
      else $error("hit count beyond cap");
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      emit_valid |-> slot_free)
      else $error("result pushed into a full output slot");
   a_idle_no_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_v_ff)
      else $error("held hit left behind at end of scan");
`endif

endmodule

// ===== hw/rtl/aho_corasick_matcher.sv =====
`timescale 1ns / 1ps
// Aho-Corasick multi-pattern byte matcher. Words on the req_ channel carry
// a cmd: insert adds one pattern byte to the trie (pattern_end closes the
// pattern and gives it the next id), build computes failure and dictionary
// links breadth first and answers with one build word (overflow set if the
// node or pattern store ran out), scan walks one text byte and answers with
// every pattern ending there, last set on the final word and overflow set on
// it when hits beyond the cap were dropped. All state sits in simple
// dual-port memories (one write port, one read port with registered read
// data), driven by one sequencer that handles one word at a time. After
// reset a clearing pass writes the whole goto table, MAX_NODES * ALPHABET
// entries (262144), during which no word is accepted. An insert that closes
// a pattern also walks the node's id chain to append the new id, and the
// rest of a dropped pattern is skipped; a scan follows failure links, then
// visits dictionary nodes and reports their hits; a build visits every root
// symbol and every (node, symbol) pair, plus the failure chase of every
// node. One output register holds a result word, so the sequencer keeps
// working while one word waits to be taken; a further result stalls it
// until rsp_ready frees the register.
module aho_corasick_matcher (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [acm_pkg::CMD_W-1:0]     req_cmd,
   input  logic [acm_pkg::SYM_W-1:0]     req_symbol,
   input  logic                          req_pattern_end,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_kind,
   output logic [acm_pkg::ID_W-1:0]      rsp_pattern_id,
   output logic [acm_pkg::START_W-1:0]   rsp_start_pos,
   output logic                          rsp_overflow,
   output logic                          rsp_last
);
   import acm_pkg::*;

   logic       emit_valid;
   result_type emit;
   logic       slot_free;

   // output register
   logic       out_v_ff, out_v_in;
   result_type out_ff, out_in;

   acm_core u_core (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_symbol      (req_symbol),
      .req_pattern_end (req_pattern_end),
      .emit_valid      (emit_valid),
      .emit            (emit),
      .slot_free       (slot_free)
   );

   // slot is free when empty or when its word leaves this cycle
   assign slot_free = !out_v_ff || rsp_ready;

   always_comb begin
      out_v_in = out_v_ff;
      out_in   = out_ff;
      if (emit_valid) begin
         out_v_in = 1'b1;
         out_in   = emit;
      end else if (rsp_ready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_kind       = out_ff.kind;
   assign rsp_pattern_id = out_ff.pattern_id;
   assign rsp_start_pos  = out_ff.start_pos;
   assign rsp_overflow   = out_ff.overflow;
   assign rsp_last       = out_ff.last;

endmodule

// ===== tb/sv/aho_corasick_matcher_tb.sv =====
`timescale 1ns / 1ps
module aho_corasick_matcher_tb;
   import acm_pkg::*;

   // how a stimulus row is checked
   typedef enum int {CHK_MODEL, CHK_NONE, CHK_BUILD} chk_type;

   typedef struct {
      logic [CMD_W-1:0] cmd;
      logic [SYM_W-1:0] sym;
      logic             eop;
      chk_type          chk;
   } stim_row_type;

   // one pattern of the library, kept for reuse in the last phase
   typedef struct {
      int         len;
      logic [7:0] b [4];
   } pattern_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [CMD_W-1:0]    req_cmd;
   logic [SYM_W-1:0]    req_symbol;
   logic                req_pattern_end;
   logic                rsp_valid;
   logic                rsp_ready;
   logic                rsp_kind;
   logic [ID_W-1:0]     rsp_pattern_id;
   logic [START_W-1:0]  rsp_start_pos;
   logic                rsp_overflow;
   logic                rsp_last;

   aho_corasick_matcher DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_symbol      (req_symbol),
      .req_pattern_end (req_pattern_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_pattern_id  (rsp_pattern_id),
      .rsp_start_pos   (rsp_start_pos),
      .rsp_overflow    (rsp_overflow),
      .rsp_last        (rsp_last)
   );

   // 10 ns clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------------------------------------------------------
   // matcher mirror: trie, links and pattern chains
   // ---------------------------------------------------------------
   int         trie_edge [int];          // node*ALPHABET+sym -> child, absent = invalid
   int         fail_of   [MAX_NODES];
   bit         dict_ok   [MAX_NODES];
   int         dict_of   [MAX_NODES];
   bit         first_ok  [MAX_NODES];
   int         first_id  [MAX_NODES];
   int         depth_of  [MAX_NODES];
   bit         chain_ok  [MAX_PATTERNS];
   int         chain_nx  [MAX_PATTERNS];
   int         nodes_used;
   int         ids_used;
   int         cur_insert;
   int         cur_scan;
   logic [19:0] text_at;
   bit         store_full;
   bit         drop_pat;

   result_type match_q [$];    // words still owed by the block
   bit         bad;
   bit         calm;           // no idling on either side
   bit         gap_on;
   pattern_type lib [$];

   function automatic int edge_key(int node, int sym);
      return node * ALPHABET + sym;
   endfunction

   function automatic void mirror_reset();
      trie_edge.delete();
      for (int i = 0; i < MAX_NODES; i++) begin
         fail_of[i] = 0; dict_ok[i] = 0; dict_of[i] = 0;
         first_ok[i] = 0; first_id[i] = 0; depth_of[i] = 0;
      end
      for (int i = 0; i < MAX_PATTERNS; i++) begin
         chain_ok[i] = 0; chain_nx[i] = 0;
      end
      nodes_used = 1; ids_used = 0; cur_insert = 0; cur_scan = 0;
      text_at = '0; store_full = 0; drop_pat = 0;
   endfunction

   function automatic void mirror_insert(int sym, bit eop);
      int k;
      int n;
      int id;
      int p;
      k = edge_key(cur_insert, sym);
      if (!drop_pat) begin
         if (trie_edge.exists(k)) begin
            cur_insert = trie_edge[k];
         end else if (nodes_used >= MAX_NODES ||
                      depth_of[cur_insert] + 1 > MAX_PATTERN_LEN) begin
            store_full = 1;
            drop_pat = 1;
         end else begin
            n = nodes_used++;
            fail_of[n] = 0; dict_ok[n] = 0; dict_of[n] = 0; first_ok[n] = 0;
            depth_of[n] = depth_of[cur_insert] + 1;
            trie_edge[k] = n;
            cur_insert = n;
         end
      end
      if (eop) begin
         if (ids_used >= MAX_PATTERNS) begin
            store_full = 1;
         end else begin
            id = ids_used++;
            // dropped or empty patterns burn the id without registering
            if (!drop_pat && cur_insert != 0) begin
               chain_ok[id] = 0;
               if (!first_ok[cur_insert]) begin
                  first_ok[cur_insert] = 1;
                  first_id[cur_insert] = id;
               end else begin
                  p = first_id[cur_insert];
                  while (chain_ok[p]) p = chain_nx[p];
                  chain_ok[p] = 1;
                  chain_nx[p] = id;
               end
            end
         end
         cur_insert = 0;
         drop_pat = 0;
      end
   endfunction

   function automatic void mirror_build(ref result_type out [$]);
      int         bfs [$];
      int         u;
      int         v;
      int         f;
      int         w;
      result_type r;
      for (int c = 0; c < ALPHABET; c++) begin
         if (trie_edge.exists(c)) begin
            v = trie_edge[c];
            fail_of[v] = 0; dict_ok[v] = 0;
            bfs.insert(bfs.size(), v);
         end
      end
      while (bfs.size() != 0) begin
         u = bfs.pop_front();
         for (int c = 0; c < ALPHABET; c++) begin
            if (!trie_edge.exists(edge_key(u, c))) continue;
            v = trie_edge[edge_key(u, c)];
            bfs.insert(bfs.size(), v);
            f = fail_of[u];
            while (f != 0 && !trie_edge.exists(edge_key(f, c))) f = fail_of[f];
            w = trie_edge.exists(edge_key(f, c)) ? trie_edge[edge_key(f, c)] : 0;
            fail_of[v] = w;
            if (first_ok[w]) begin
               dict_ok[v] = 1; dict_of[v] = w;
            end else begin
               dict_ok[v] = dict_ok[w]; dict_of[v] = dict_of[w];
            end
         end
      end
      cur_scan = 0;
      text_at = '0;
      r.kind = KIND_BUILD; r.pattern_id = '0; r.start_pos = '0;
      r.overflow = store_full; r.last = 1'b1;
      out.insert(out.size(), r);
   endfunction

   function automatic void mirror_scan(int sym, ref result_type out [$]);
      int         hits;
      bit         dropped;
      bit         vv;
      int         vn;
      int         node;
      bit         pv;
      int         p;
      result_type r;
      hits = 0; dropped = 0;
      while (cur_scan != 0 && !trie_edge.exists(edge_key(cur_scan, sym)))
         cur_scan = fail_of[cur_scan];
      cur_scan = trie_edge.exists(edge_key(cur_scan, sym)) ?
                 trie_edge[edge_key(cur_scan, sym)] : 0;
      vv = first_ok[cur_scan] ? 1'b1 : dict_ok[cur_scan];
      vn = first_ok[cur_scan] ? cur_scan : dict_of[cur_scan];
      // walk the dictionary chain, every id on every node
      while (vv && !dropped) begin
         node = vn;
         pv = first_ok[node];
         p = first_id[node];
         while (pv) begin
            if (hits >= MAX_HITS) begin
               dropped = 1;
               break;
            end
            r.kind = KIND_MATCH;
            r.pattern_id = p[ID_W-1:0];
            r.start_pos = text_at - 20'(depth_of[node]) + 20'd1;
            r.overflow = 1'b0;
            r.last = 1'b0;
            out.insert(out.size(), r);
            hits++;
            pv = chain_ok[p];
            p = chain_nx[p];
         end
         vv = dict_ok[node];
         vn = dict_of[node];
      end
      if (hits > 0) begin
         out[out.size()-1].last = 1'b1;
         out[out.size()-1].overflow = dropped;
      end
      text_at = text_at + 20'd1;
   endfunction

   // ---------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------
   task automatic send_word(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] sym, logic eop,
                            chk_type chk);
      result_type owed [$];
      result_type r;
      if (!calm && gap_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_symbol      <= sym;
      req_pattern_end <= eop;
      // ready is stable between the falling edge and the next rising edge
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      case (cmd)
         CMD_INSERT: mirror_insert(sym, eop);
         CMD_BUILD:  mirror_build(owed);
         CMD_SCAN:   mirror_scan(sym, owed);
         default: ;
      endcase
      if (chk == CHK_MODEL) begin
         foreach (owed[i]) match_q.insert(match_q.size(), owed[i]);
      end else if (chk == CHK_BUILD) begin
         r.kind = KIND_BUILD; r.pattern_id = '0; r.start_pos = '0;
         r.overflow = 1'b0; r.last = 1'b1;
         match_q.insert(match_q.size(), r);
      end
   endtask

   task automatic send_pattern(pattern_type pt);
      for (int i = 0; i < pt.len; i++)
         send_word(CMD_INSERT, pt.b[i], i == pt.len - 1, CHK_MODEL);
   endtask

   // mostly a small alphabet so that matches pile up, now and then any byte
   function automatic logic [7:0] pick_symbol();
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
      return 8'("a" + $urandom_range(0, 3));
   endfunction

   function automatic pattern_type new_pattern();
      pattern_type pt;
      pt.len = $urandom_range(1, 4);
      for (int i = 0; i < 4; i++) pt.b[i] = pick_symbol();
      return pt;
   endfunction

   stim_row_type directed [] = '{
      '{CMD_SCAN,   "a",   1'b0, CHK_NONE},   // scan with an empty trie
      '{CMD_RSVD,   8'hA5, 1'b1, CHK_NONE},   // unknown cmd is ignored
      '{CMD_INSERT, "h",   1'b0, CHK_NONE},
      '{CMD_INSERT, "e",   1'b1, CHK_NONE},
      '{CMD_INSERT, "s",   1'b0, CHK_NONE},
      '{CMD_INSERT, "h",   1'b0, CHK_NONE},
      '{CMD_INSERT, "e",   1'b1, CHK_NONE},
      '{CMD_INSERT, "h",   1'b0, CHK_NONE},
      '{CMD_INSERT, "i",   1'b0, CHK_NONE},
      '{CMD_INSERT, "s",   1'b1, CHK_NONE},
      '{CMD_INSERT, "h",   1'b0, CHK_NONE},
      '{CMD_INSERT, "e",   1'b0, CHK_NONE},
      '{CMD_INSERT, "r",   1'b0, CHK_NONE},
      '{CMD_INSERT, "s",   1'b1, CHK_NONE},
      '{CMD_INSERT, 8'h00, 1'b1, CHK_NONE},
      '{CMD_INSERT, 8'hFF, 1'b1, CHK_NONE},
      '{CMD_SCAN,   "h",   1'b0, CHK_MODEL},  // scan before build
      '{CMD_BUILD,  8'h00, 1'b0, CHK_BUILD},
      '{CMD_SCAN,   "s",   1'b0, CHK_MODEL},
      '{CMD_SCAN,   "h",   1'b0, CHK_MODEL},
      '{CMD_SCAN,   "e",   1'b0, CHK_MODEL},
      '{CMD_SCAN,   "r",   1'b0, CHK_MODEL},
      '{CMD_SCAN,   "s",   1'b0, CHK_MODEL},
      '{CMD_SCAN,   8'hFF, 1'b1, CHK_MODEL},
      '{CMD_SCAN,   8'h00, 1'b0, CHK_MODEL}
   };

   initial begin
      pattern_type pt;
      int          pick;
      bad = 0; calm = 0; gap_on = 1;
      mirror_reset();
      reset <= 1'b1;
      req_valid <= 1'b0; req_cmd <= '0; req_symbol <= '0; req_pattern_end <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed rows
      foreach (directed[i])
         send_word(directed[i].cmd, directed[i].sym, directed[i].eop, directed[i].chk);

      // random phases: load a few patterns, build, then scan text
      for (int ph = 0; ph < 5; ph++) begin
         gap_on = (ph != 2);
         for (int j = 0; j < 5; j++) begin
            pt = new_pattern();
            lib.insert(lib.size(), pt);
            send_pattern(pt);
            pick = $urandom_range(0, 5);
            if (pick == 0)
               send_word(CMD_RSVD, 8'($urandom), 1'($urandom), CHK_MODEL);
            else if (pick == 1) begin
               // broken sequence: a scan in the middle of a pattern
               send_word(CMD_INSERT, pick_symbol(), 1'b0, CHK_MODEL);
               send_word(CMD_SCAN, pick_symbol(), 1'($urandom), CHK_MODEL);
            end
         end
         send_word(CMD_BUILD, 8'($urandom), 1'($urandom), CHK_MODEL);
         for (int j = 0; j < 42; j++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
               // insert after build without a new build
               pt = new_pattern();
               lib.insert(lib.size(), pt);
               send_pattern(pt);
            end else if (pick == 1)
               send_word(CMD_RSVD, 8'($urandom), 1'($urandom), CHK_MODEL);
            else
               send_word(CMD_SCAN, pick_symbol(), 1'($urandom), CHK_MODEL);
         end
      end

      // last part, no idling: hit cap, then a second id for a known pattern
      calm = 1;
      for (int j = 0; j < 70; j++) send_word(CMD_INSERT, "z", 1'b1, CHK_MODEL);
      send_word(CMD_BUILD, 8'h00, 1'b0, CHK_MODEL);
      repeat (3) send_word(CMD_SCAN, "z", 1'b0, CHK_MODEL);
      send_pattern(lib[0]);
      send_word(CMD_BUILD, 8'h00, 1'b0, CHK_MODEL);
      repeat (5) send_word(CMD_SCAN, pick_symbol(), 1'b0, CHK_MODEL);
      req_valid <= 1'b0;

      // drain, then give stray words a chance to show up
      while (match_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (!bad && match_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // ---------------------------------------------------------------
   // response side: ready bursts, check at the falling edge
   // ---------------------------------------------------------------
   int stall_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(negedge clock) begin
      result_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (match_q.size() == 0) begin
            $error("unexpected word: kind %0d id %0d start %0d", rsp_kind,
                   rsp_pattern_id, rsp_start_pos);
            bad = 1;
         end else begin
            w = match_q.pop_front();
            if (rsp_kind !== w.kind) begin
               $error("kind: expected %0d actual %0d", w.kind, rsp_kind);
               bad = 1;
            end
            if (rsp_pattern_id !== w.pattern_id) begin
               $error("pattern_id: expected %0d actual %0d", w.pattern_id,
                      rsp_pattern_id);
               bad = 1;
            end
            if (rsp_start_pos !== w.start_pos) begin
               $error("start_pos: expected %0d actual %0d", w.start_pos,
                      rsp_start_pos);
               bad = 1;
            end
            if (rsp_overflow !== w.overflow) begin
               $error("overflow: expected %0d actual %0d", w.overflow, rsp_overflow);
               bad = 1;
            end
            if (rsp_last !== w.last) begin
               $error("last: expected %0d actual %0d", w.last, rsp_last);
               bad = 1;
            end
         end
      end
   end

   // run limit, well beyond the clearing pass and every build
   initial begin
      #40ms;
      $display("tb: failure");
      $finish;
   end

endmodule
